// ===== rtl/ata_cf_task_file_device_top_macros.svh =====
// Assertion macros for the task-file device
`ifndef ATA_CF_TASK_FILE_DEVICE_TOP_MACROS_SVH
`define ATA_CF_TASK_FILE_DEVICE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ATF_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ATF_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ATF_ASSERT_IMP(label, clk, rst_n, a, c)
`define ATF_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/atacf_pkg.sv =====
package atacf_pkg;
  localparam int unsigned SECTORS      = 64;
  localparam int unsigned SECTOR_WORDS = 256;
  localparam int unsigned STORE_WORDS  = SECTORS * SECTOR_WORDS;
  localparam int unsigned ADDR_W       = $clog2(STORE_WORDS);

  localparam logic [1:0] MODE_RD   = 2'd0;
  localparam logic [1:0] MODE_WR   = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [3:0] RA_DATA = 4'd0;
  localparam logic [3:0] RA_FEAT = 4'd1;
  localparam logic [3:0] RA_CNT  = 4'd2;
  localparam logic [3:0] RA_LBAL = 4'd3;
  localparam logic [3:0] RA_LBAM = 4'd4;
  localparam logic [3:0] RA_LBAH = 4'd5;
  localparam logic [3:0] RA_DEV  = 4'd6;
  localparam logic [3:0] RA_CMD  = 4'd7;
  localparam logic [3:0] RA_ALT  = 4'd8;

  localparam logic [7:0] CMD_IDENT  = 8'hec;
  localparam logic [7:0] CMD_READ   = 8'h20;
  localparam logic [7:0] CMD_WRITE  = 8'h30;
  localparam logic [7:0] CMD_XLATE  = 8'h87;
  localparam logic [7:0] CMD_CHKPWR = 8'he5;

  // Commands that are accepted and do nothing
  localparam logic [7:0] CMD_STBY_IMM    = 8'he0;
  localparam logic [7:0] CMD_IDLE_IMM    = 8'he1;
  localparam logic [7:0] CMD_STBY        = 8'he2;
  localparam logic [7:0] CMD_IDLE        = 8'he3;
  localparam logic [7:0] CMD_SLEEP       = 8'he6;
  localparam logic [7:0] CMD_SET_FEAT    = 8'hef;
  localparam logic [7:0] CMD_CFA_ERASE   = 8'hc0;
  localparam logic [7:0] CMD_CFA_REQ_ERR = 8'h03;
  localparam logic [7:0] CMD_INIT_PARAM  = 8'h91;
  localparam logic [7:0] CMD_SET_MULT    = 8'hc6;

  localparam logic [7:0] ST_READY = 8'h50;
  localparam logic [7:0] ST_DRQ   = 8'h08;
  localparam logic [7:0] ST_ERR   = 8'h01;
  localparam logic [7:0] ER_ABRT  = 8'h04;

  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_STORE = 2'd1;
  localparam logic [1:0] SRC_IDENT = 2'd2;
  localparam logic [1:0] SRC_ZERO  = 2'd3;

  // Request from the task file to the store
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       wdata;
  } st_req_t;

  // Identify word, already byte-swapped as returned on the bus
  function automatic logic [15:0] ident_swapped(input logic [7:0] i);
    logic [31:0] total;
    logic [15:0] w;
    total = 32'(SECTORS);
    w = 16'h0000;
    if (i >= 8'd10 && i < 8'd20) begin
      case (i)
        8'd10, 8'd14: w = 16'h4F43;
        8'd11: w = 16'h5441;
        8'd12: w = 16'h4241;
        8'd13: w = 16'h4D30;
        8'd15: w = 16'h3120;
        default: w = 16'h2020;
      endcase
      if (i == 8'd14) w = 16'h3030;
    end else if (i >= 8'd23 && i < 8'd27) begin
      case (i)
        8'd23: w = 16'h312E;
        8'd24: w = 16'h3020;
        default: w = 16'h2020;
      endcase
    end else if (i >= 8'd27 && i < 8'd37) begin
      case (i)
        8'd27: w = 16'h4F43;
        8'd28: w = 16'h5441;
        8'd29: w = 16'h4241;
        8'd30: w = 16'h4D20;
        8'd31: w = 16'h454D;
        8'd32: w = 16'h554C;
        8'd33: w = 16'h4154;
        8'd34: w = 16'h4544;
        8'd35: w = 16'h2043;
        default: w = 16'h4620;
      endcase
    end else if (i >= 8'd37 && i < 8'd47) begin
      w = 16'h2020;
    end else begin
      case (i)
        8'd0: w = 16'h848a;
        8'd1, 8'd54: w = 16'd1024;
        8'd3, 8'd55: w = 16'd16;
        8'd6, 8'd56: w = 16'd63;
        8'd7, 8'd58, 8'd61: w = total[31:16];
        8'd8, 8'd57, 8'd60: w = total[15:0];
        8'd47: w = 16'h8001;
        8'd49, 8'd51: w = 16'h0200;
        default: w = 16'h0000;
      endcase
    end
    return {w[7:0], w[15:8]};
  endfunction
endpackage

// ===== rtl/atacf_store.sv =====
// Sector store: one write or one read per cycle, registered read data
module atacf_store (
  input  logic                   clk,
  input  atacf_pkg::st_req_t     req,
  output logic [15:0]            rdata
);
  import atacf_pkg::*;

  logic [15:0] mem [STORE_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr) mem[req.addr] <= req.wdata;
    if (req.rd) rdata <= mem[req.addr];
  end
endmodule

// ===== rtl/atacf_regs.sv =====
// Task-file registers and command decode; issues store requests
module atacf_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [1:0]          mode,
  input  logic [3:0]          reg_address,
  input  logic [15:0]         value,
  input  logic [13:0]         image_address,
  output atacf_pkg::st_req_t  req,
  output logic                use_store,
  output logic [15:0]         rval
);
  import atacf_pkg::*;
  `include "ata_cf_task_file_device_top_macros.svh"

  logic [7:0]  feature_r, count_r, lbal_r, lbam_r, lbah_r, dev_r, status_r, error_r;
  logic [1:0]  src_r;
  logic [27:0] base_r, wsec_r;
  logic [16:0] pos_r, len_r;
  logic [8:0]  wrem_r;
  logic [7:0]  widx_r;

  logic [27:0] lba;
  logic [8:0]  cnt;
  logic [28:0] endsec;
  logic [28:0] nsec;
  logic        rd_data, wr_data, wr_cmd;
  logic [7:0]  b;
  logic [15:0] rv;
  logic [ADDR_W-1:0] rd_addr;

  assign lba    = {dev_r[3:0], lbah_r, lbam_r, lbal_r};
  assign cnt    = (count_r == 8'd0) ? 9'd256 : {1'b0, count_r};
  assign endsec = 29'(lba) + 29'(cnt);
  assign nsec   = (endsec > 29'(SECTORS)) ? 29'(SECTORS) - 29'(lba) : 29'(cnt);
  assign b      = value[7:0];
  assign rd_data = go && mode == MODE_RD && reg_address == RA_DATA;
  assign wr_data = go && mode == MODE_WR && reg_address == RA_DATA;
  assign wr_cmd  = go && mode == MODE_WR && reg_address == RA_CMD;
  assign rd_addr = ADDR_W'(base_r * 28'(SECTOR_WORDS) + 28'(pos_r));

  // Store request and immediate read value
  always_comb begin
    req = '0;
    rv = 16'h0000;
    use_store = 1'b0;
    if (go && mode == MODE_LOAD && 32'(image_address) < STORE_WORDS) begin
      req.wr = 1'b1;
      req.addr = ADDR_W'(image_address);
      req.wdata = value;
    end
    if (wr_data && wrem_r != 9'd0 && 32'(wsec_r) < SECTORS) begin
      req.wr = 1'b1;
      req.addr = ADDR_W'(wsec_r) * ADDR_W'(SECTOR_WORDS) + ADDR_W'(widx_r);
      req.wdata = value;
    end
    if (go && mode == MODE_RD) begin
      case (reg_address)
        RA_DATA: begin
          if (pos_r < len_r) begin
            if (src_r == SRC_STORE && 32'(base_r) < SECTORS) begin
              req.rd = 1'b1;
              req.addr = rd_addr;
              use_store = 1'b1;
            end else if (src_r == SRC_IDENT) begin
              rv = ident_swapped(pos_r[7:0]);
            end
          end
        end
        RA_FEAT: rv = {8'h00, error_r};
        RA_CNT:  rv = {8'h00, count_r};
        RA_LBAL: rv = {8'h00, lbal_r};
        RA_LBAM: rv = {8'h00, lbam_r};
        RA_LBAH: rv = {8'h00, lbah_r};
        RA_DEV:  rv = {8'h00, dev_r};
        RA_CMD, RA_ALT: rv = {8'h00, status_r};
        default: rv = 16'h0000;
      endcase
    end
  end
  assign rval = rv;

  // Register state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feature_r <= '0; count_r <= '0; lbal_r <= '0; lbam_r <= '0; lbah_r <= '0;
      dev_r <= '0; status_r <= ST_READY; error_r <= '0; src_r <= SRC_NONE;
      base_r <= '0; pos_r <= '0; len_r <= '0; wsec_r <= '0; wrem_r <= '0;
      widx_r <= '0;
    end else begin
      if (rd_data && pos_r < len_r) begin
        pos_r <= pos_r + 17'd1;
        if (pos_r + 17'd1 >= len_r) status_r <= status_r & ~ST_DRQ;
      end
      if (wr_data && wrem_r != 9'd0) begin
        widx_r <= widx_r + 8'd1;
        if (widx_r == 8'hff) begin
          if (wsec_r != 28'hfffffff) wsec_r <= wsec_r + 28'd1;
          wrem_r <= wrem_r - 9'd1;
          if (wrem_r == 9'd1) status_r <= status_r & ~ST_DRQ;
        end
      end
      if (go && mode == MODE_WR) begin
        case (reg_address)
          RA_FEAT: feature_r <= b;
          RA_CNT:  count_r <= b;
          RA_LBAL: lbal_r <= b;
          RA_LBAM: lbam_r <= b;
          RA_LBAH: lbah_r <= b;
          RA_DEV:  dev_r <= b;
          default: ;
        endcase
      end
      // Command: error cleared and status back to ready unless it aborts
      if (wr_cmd) begin
        case (b)
          CMD_IDENT, CMD_XLATE: begin
            src_r <= (b == CMD_IDENT) ? SRC_IDENT : SRC_ZERO;
            pos_r <= '0;
            len_r <= 17'(SECTOR_WORDS);
            error_r <= 8'h00;
            status_r <= ST_READY | ST_DRQ;
          end
          CMD_READ: begin
            src_r <= SRC_STORE;
            pos_r <= '0;
            base_r <= lba;
            len_r <= (32'(lba) >= SECTORS) ? 17'd0 : {nsec[8:0], 8'h00};
            error_r <= 8'h00;
            status_r <= ST_READY | ST_DRQ;
          end
          CMD_WRITE: begin
            wsec_r <= lba;
            wrem_r <= cnt;
            widx_r <= '0;
            error_r <= 8'h00;
            status_r <= ST_READY | ST_DRQ;
          end
          CMD_CHKPWR: begin
            count_r <= 8'hff;
            error_r <= 8'h00;
            status_r <= ST_READY;
          end
          CMD_STBY_IMM, CMD_IDLE_IMM, CMD_STBY, CMD_IDLE, CMD_SLEEP,
          CMD_SET_FEAT, CMD_CFA_ERASE, CMD_CFA_REQ_ERR, CMD_INIT_PARAM,
          CMD_SET_MULT: begin
            error_r <= 8'h00;
            status_r <= ST_READY;
          end
          default: begin
            error_r <= ER_ABRT;
            status_r <= ST_READY | ST_ERR;
          end
        endcase
      end
    end
  end

  `ATF_ASSERT_IMP(a_rw_excl, clk, rst_n, 1'b1, !(req.rd && req.wr))
  `ATF_ASSERT_IMP(a_pos_len, clk, rst_n, 1'b1, pos_r <= len_r)
  `ATF_ASSERT_IMP(a_store_rd, clk, rst_n, use_store, rd_data)
endmodule

// ===== rtl/ata_cf_task_file_device_top.sv =====
// Channel | Dir | Contents
// in_     | in  | tdata: mode[1:0] reg_address[5:2] value[21:6] image_address[35:22]
// out_    | out | tdata: read_value[15:0]
// An item passes two steps: accept/store access, then the registered store read (or the
// held register value) lands in the output register. No new item is accepted meanwhile.
// Reset is synchronous, active low; the store itself is not cleared.
// A full output register that is not taken holds off the input.
module ata_cf_task_file_device_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mode, reg_address, value, image_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_value
);
  import atacf_pkg::*;
  `include "ata_cf_task_file_device_top_macros.svh"

  st_req_t     req;
  logic [15:0] sdata, rval, rval_r, out_r;
  logic        go, busy_r, use_r, ov_r;
  logic        use_store_w;

  // A pending item occupies stage one and holds off the input
  assign in_tready = !busy_r && (!ov_r || out_tready);
  assign go = in_tvalid && in_tready;

  atacf_regs u_regs (
    .clk(clk), .rst_n(rst_n), .go(go),
    .mode(in_tdata[1:0]), .reg_address(in_tdata[5:2]),
    .value(in_tdata[21:6]), .image_address(in_tdata[35:22]),
    .req(req), .use_store(use_store_w), .rval(rval)
  );

  atacf_store u_store (.clk(clk), .req(req), .rdata(sdata));

  // Stage then output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      busy_r <= go;
      if (busy_r) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    if (go) begin
      rval_r <= rval;
      use_r <= use_store_w;
    end
    if (busy_r) out_r <= use_r ? sdata : rval_r;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = out_r;

  `ATF_ASSERT_NXT(a_no_back, clk, rst_n, go, !go)
  `ATF_ASSERT_IMP(a_no_drop, clk, rst_n, busy_r && ov_r, $past(out_tready))
  `ATF_ASSERT_NXT(a_fill, clk, rst_n, busy_r, ov_r)
endmodule
